[design/mbfb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbfb_pkg;

  localparam int unsigned LenW   = 11;
  localparam int unsigned CountW = 6;
  localparam int unsigned FieldW = 32;
  localparam int unsigned OpW    = 2;

  localparam logic [LenW-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [OpW-1:0] {
    OP_REWIND = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_ACCESS = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

endpackage

`default_nettype wire

[design/mbfb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbfb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[design/msb_first_bit_field_buffer.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   op_i, bit_count_i, value_i
// out      output     out_valid_o / out_stall_i read_data_o, ok_o
// cfg      input      cfg_we_i                  cfg_wdata_i (length_bits)
//
// rewind, failed access or unused op: straight from idle to finish, store untouched
// read or write touching k bytes (1 to 5): one byte of the byte-wide store read
//   per cycle and, on a write, written back
// after reset a clearing pass zeroes every byte of the store,
//   no item taken meanwhile, register writes taken as ever
// a finished result waits in the output register while the next item runs

module msb_first_bit_field_buffer
  import mbfb_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES   = 128,
  parameter int unsigned MAX_FIELD_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LenW-1:0]   cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [OpW-1:0]    op_i,
  input  wire logic [CountW-1:0] bit_count_i,
  input  wire logic [FieldW-1:0] value_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [FieldW-1:0]      read_data_o,
  output logic                   ok_o
);

  localparam int unsigned AddrW    = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned KMax     = (MAX_FIELD_BITS + 14) / 8;
  localparam int unsigned WinW     = 8 * KMax;
  localparam int unsigned CntW     = $clog2(KMax + 1);
  localparam int unsigned IdxW     = (KMax > 1) ? $clog2(KMax) : 1;
  localparam int unsigned ShW      = $clog2(WinW + 1);
  localparam int unsigned CapBits  = BUFFER_BYTES * 8;
  localparam int unsigned MaxLen   = (1 << LenW) - 1;
  localparam logic [LenW-1:0]  CapClamp = LenW'((CapBits > MaxLen) ? MaxLen : CapBits);
  localparam logic [AddrW-1:0] ClrLast  = AddrW'(BUFFER_BYTES - 1);

  typedef logic [0:KMax-1][7:0] win_t;

  state_e            state_q, state_d;
  logic [LenW-1:0]   length_q;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [FieldW-1:0] read_data_q;
  logic              ok_out_q;

  // item registers
  logic              rewind_q, go_q, read_q, write_q, ok_res_q;
  logic [CountW-1:0] n_q;
  logic [ShW-1:0]    sh_q;
  logic [WinW-1:0]   lowmask_q;
  win_t              mask_q, data_q, acc_q;
  logic [CntW-1:0]   k_q;
  logic [AddrW-1:0]  base_q;

  // item decode
  logic [LenW-1:0]   usable, room;
  logic              is_rw, n_zero, fits, go_in, ok_in, accept, load_out;
  logic [2:0]        s_in;
  logic [6:0]        span;
  logic [ShW-1:0]    sh_in;
  logic [WinW-1:0]   lowmask_in;
  logic [IdxW-1:0]   j;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  assign usable = (length_q < CapClamp) ? length_q : CapClamp;
  assign room   = (pos_q < usable) ? (usable - pos_q) : '0;
  assign is_rw  = (op_i == OP_READ) || (op_i == OP_WRITE);
  assign n_zero = (bit_count_i == '0);
  assign fits   = (bit_count_i <= CountW'(MAX_FIELD_BITS)) &&
                  (LenW'(bit_count_i) <= room);
  assign go_in  = is_rw && !n_zero && fits;
  assign ok_in  = (op_i == OP_REWIND) || (is_rw && (n_zero || fits));

  assign s_in       = pos_q[2:0];
  assign span       = 7'(s_in) + 7'(bit_count_i) - 7'd1;
  assign sh_in      = ShW'(WinW) - ShW'(s_in) - ShW'(bit_count_i);
  assign lowmask_in = ~({WinW{1'b1}} << bit_count_i);

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign j      = IdxW'(cnt_q - CntW'(1));

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    load_out    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (go_in) begin
            state_d = S_ACCESS;
            cnt_d   = CntW'(1);
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_ACCESS: begin
        if (cnt_q == k_q) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (rewind_q) begin
            pos_d = '0;
          end else if (go_q) begin
            pos_d = pos_q + LenW'(n_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      length_q    <= LEN_RESET;
      pos_q       <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        length_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rewind_q  <= (op_i == OP_REWIND);
      read_q    <= (op_i == OP_READ);
      write_q   <= (op_i == OP_WRITE);
      go_q      <= go_in;
      ok_res_q  <= ok_in;
      n_q       <= bit_count_i;
      sh_q      <= sh_in;
      lowmask_q <= lowmask_in;
      mask_q    <= lowmask_in << sh_in;
      data_q    <= (WinW'(value_i) & lowmask_in) << sh_in;
      k_q       <= CntW'(span[6:3]) + CntW'(1);
      base_q    <= AddrW'(pos_q[LenW-1:3]);
    end
    if (state_q == S_ACCESS) begin
      acc_q[j] <= ram_rdata;
    end
    if (load_out) begin
      ok_out_q    <= ok_res_q;
      read_data_q <= (go_q && read_q) ? FieldW'((acc_q >> sh_q) & lowmask_q) : '0;
    end
  end

  // byte merge, one byte per cycle while the next one is being fetched; zero fill while clearing
  assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_ACCESS) && write_q);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : (base_q + AddrW'(j));
  assign ram_wdata = (state_q == S_CLEAR) ? 8'h00 :
                     ((ram_rdata & ~mask_q[j]) | (data_q[j] & mask_q[j]));
  assign ram_raddr = (state_q == S_IDLE) ? AddrW'(pos_q[LenW-1:3]) :
                     (base_q + AddrW'(cnt_q));

  mbfb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign ok_o        = ok_out_q;

  a_pos_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CapClamp)
    else $error("bit position beyond store");

  a_out_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside finish");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) || (state_q == S_FINISH) |-> !ram_we)
    else $error("store written between items");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS) |-> (cnt_q != '0) && (cnt_q <= k_q))
    else $error("byte counter out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> (read_data_o == '0))
    else $error("failed transfer carries data");

endmodule

`default_nettype wire
